// File: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types, constants and codes of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_WIDTH  = 8;
   localparam int CELL_COUNT = ROWS * COLUMNS;

   // field widths
   localparam int OP_W   = 2;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int CELL_W = ATTR_W + CHAR_W;
   localparam int LOC_W  = 11;
   localparam int ADDR_W = $clog2(CELL_COUNT);

   // request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // attribute after reset
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'h7F;

   // request opcodes
   typedef enum logic [OP_W-1:0] {
      OP_PUT    = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_READ   = 2'd2,
      OP_UNUSED = 2'd3
   } opcode_type;

   // classified command kinds
   typedef enum logic [2:0] {
      CMD_WRITE = 3'd0,
      CMD_BACK  = 3'd1,
      CMD_TAB   = 3'd2,
      CMD_CR    = 3'd3,
      CMD_LF    = 3'd4,
      CMD_CLEAR = 3'd5,
      CMD_READ  = 3'd6,
      CMD_NOP   = 3'd7
   } cmd_kind_type;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [CHAR_W-1:0] char_byte;
      logic [ROW_W-1:0]  read_row;
      logic [COL_W-1:0]  read_column;
   } req_type;

   typedef struct packed {
      logic [LOC_W-1:0]  cursor_location;
      logic [ROW_W-1:0]  top_row;
      logic [CELL_W-1:0] read_cell;
      logic              read_valid;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [CHAR_W-1:0] char_byte;
      logic [ROW_W-1:0]  read_row;
      logic [COL_W-1:0]  read_column;
   } cmd_type;

endpackage

// File: hdl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// 80x25 text console with a ring of rows, a cursor and a top row pointer
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  tcw_pkg::req_type
//   rsp_      out         rsp_valid / rsp_stall  tcw_pkg::rsp_type
//   csr_      in          csr_write_enable       csr_write_data (attribute)
//
// a character, control code or no-op is handled in the idle state; a read also passes ST_READ
// (registered store read); a scroll or a clear adds a fill pass: one store write per cycle, single write port,
// and the response is loaded in the reply state after the last write
// after reset every cell of the store is cleared to zero with req_stall held high
// a two-entry request queue and the output register keep the two sides apart,
// so requests are still taken while a response waits on rsp_stall
//
module text_console_writer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  tcw_pkg::req_type           req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output tcw_pkg::rsp_type           rsp_payload,
   input  logic                       csr_write_enable,
   input  logic [tcw_pkg::ATTR_W-1:0] csr_write_data
);

   logic [tcw_pkg::ATTR_W-1:0] attr_ff;
   logic                       back_init;
   logic                       pop;
   logic                       empty;
   tcw_pkg::cmd_type           head_cmd;

   // attribute register
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tcw_pkg::ATTR_RESET;
      end else if (csr_write_enable) begin
         attr_ff <= csr_write_data;
      end
   end

   tcw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .back_init   (back_init),
      .pop         (pop),
      .empty       (empty),
      .head_cmd    (head_cmd)
   );

   tcw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .attr        (attr_ff),
      .empty       (empty),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .back_init   (back_init),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: hdl/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue
// short first-in first-out queue of classified commands
// ----------------------------------------------------------------------------
module tcw_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tcw_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output tcw_pkg::cmd_type head_cmd
);

   tcw_pkg::cmd_type               slot_ff [tcw_pkg::QUEUE_DEPTH];
   logic [tcw_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [tcw_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [tcw_pkg::QCNT_W-1:0]     count_ff, count_in;

   localparam logic [tcw_pkg::QPTR_W-1:0] LAST_SLOT =
      tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1);
   localparam logic [tcw_pkg::QCNT_W-1:0] DEPTH_CNT =
      tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH);

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign head_cmd = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: hdl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// accepts requests, sorts them into command kinds and queues them
// ----------------------------------------------------------------------------
module tcw_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tcw_pkg::req_type req_payload,
   input  logic             back_init,
   input  logic             pop,
   output logic             empty,
   output tcw_pkg::cmd_type head_cmd
);

   tcw_pkg::cmd_type cmd;
   logic             full;
   logic             push;

   // no request taken while the store is being cleared after reset
   assign req_stall = full || back_init;
   assign push      = req_valid && !req_stall;

   // classify the request
   always_comb begin
      cmd.char_byte   = req_payload.char_byte;
      cmd.read_row    = req_payload.read_row;
      cmd.read_column = req_payload.read_column;
      cmd.kind        = tcw_pkg::CMD_NOP;
      unique case (tcw_pkg::opcode_type'(req_payload.opcode))
         tcw_pkg::OP_PUT: begin
            if (req_payload.char_byte == tcw_pkg::CHAR_BS) begin
               cmd.kind = tcw_pkg::CMD_BACK;
            end else if (req_payload.char_byte == tcw_pkg::CHAR_TAB) begin
               cmd.kind = tcw_pkg::CMD_TAB;
            end else if (req_payload.char_byte == tcw_pkg::CHAR_CR) begin
               cmd.kind = tcw_pkg::CMD_CR;
            end else if (req_payload.char_byte == tcw_pkg::CHAR_LF) begin
               cmd.kind = tcw_pkg::CMD_LF;
            end else if (req_payload.char_byte >= tcw_pkg::CHAR_SPACE &&
                         req_payload.char_byte <= tcw_pkg::CHAR_LAST) begin
               cmd.kind = tcw_pkg::CMD_WRITE;
            end
         end
         tcw_pkg::OP_CLEAR: begin
            cmd.kind = tcw_pkg::CMD_CLEAR;
         end
         tcw_pkg::OP_READ: begin
            // an out-of-range read answers like a no-op
            if (req_payload.read_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS) &&
                req_payload.read_column < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) begin
               cmd.kind = tcw_pkg::CMD_READ;
            end
         end
         default: begin
            cmd.kind = tcw_pkg::CMD_NOP;
         end
      endcase
   end

   tcw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (cmd),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .head_cmd (head_cmd)
   );

endmodule

// File: hdl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// executes commands on the cell store, cursor and top row pointer
// ----------------------------------------------------------------------------
module tcw_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [tcw_pkg::ATTR_W-1:0]   attr,
   input  logic                         empty,
   input  tcw_pkg::cmd_type             head_cmd,
   output logic                         pop,
   output logic                         back_init,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output tcw_pkg::rsp_type             rsp_payload
);

   typedef enum logic [4:0] {
      ST_INIT  = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_FILL  = 5'b01000,
      ST_REPLY = 5'b10000
   } state_type;

   localparam logic [tcw_pkg::ADDR_W-1:0] COLS_A = tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
   localparam logic [tcw_pkg::ADDR_W-1:0] LAST_CELL =
      tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);
   localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
   localparam logic [tcw_pkg::COL_W:0]   COLS_X   = (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS);
   localparam logic [tcw_pkg::COL_W:0]   TAB_X    = (tcw_pkg::COL_W+1)'(tcw_pkg::TAB_WIDTH);

   // displayed row to physical row in the ring
   function automatic logic [tcw_pkg::ROW_W-1:0] phys_row(
      input logic [tcw_pkg::ROW_W-1:0] top,
      input logic [tcw_pkg::ROW_W-1:0] shown
   );
      logic [tcw_pkg::ROW_W:0] sum;
      sum = {1'b0, top} + {1'b0, shown};
      if (sum >= (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS)) begin
         sum = sum - (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS);
      end
      return sum[tcw_pkg::ROW_W-1:0];
   endfunction

   state_type                     state_ff, state_in;
   logic [tcw_pkg::COL_W-1:0]     col_ff, col_in;
   logic [tcw_pkg::ROW_W-1:0]     row_ff, row_in;
   logic [tcw_pkg::ROW_W-1:0]     top_ff, top_in;
   logic [tcw_pkg::ADDR_W-1:0]    fill_addr_ff, fill_addr_in;
   logic [tcw_pkg::ADDR_W-1:0]    fill_last_ff, fill_last_in;
   logic                          reply_read_ff, reply_read_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_type              rsp_ff;
   logic [tcw_pkg::CELL_W-1:0]    rd_data_ff;

   logic [tcw_pkg::CELL_W-1:0]    store [tcw_pkg::CELL_COUNT];

   logic                          mem_we;
   logic [tcw_pkg::ADDR_W-1:0]    mem_wa;
   logic [tcw_pkg::CELL_W-1:0]    mem_wd;
   logic                          mem_re;
   logic [tcw_pkg::ADDR_W-1:0]    mem_ra;

   logic                          out_free;
   logic                          load;
   logic                          load_read;
   logic [tcw_pkg::COL_W:0]       col_x;
   logic [tcw_pkg::COL_W:0]       col_next;
   logic                          wrap;
   logic                          step;
   logic [tcw_pkg::CELL_W-1:0]    blank;
   logic [tcw_pkg::ADDR_W-1:0]    cursor_addr;
   logic [tcw_pkg::ADDR_W-1:0]    read_addr;
   logic [tcw_pkg::ADDR_W-1:0]    top_base;

   assign back_init   = (state_ff == ST_INIT);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign blank       = {attr, tcw_pkg::CHAR_SPACE};
   assign col_x       = {1'b0, col_ff};

   // store addresses
   assign cursor_addr = tcw_pkg::ADDR_W'(phys_row(top_ff, row_ff)) * COLS_A +
                        tcw_pkg::ADDR_W'(col_ff);
   assign read_addr   = tcw_pkg::ADDR_W'(phys_row(top_ff, head_cmd.read_row)) * COLS_A +
                        tcw_pkg::ADDR_W'(head_cmd.read_column);
   assign top_base    = tcw_pkg::ADDR_W'(top_ff) * COLS_A;

   // next column of a character command
   always_comb begin
      case (head_cmd.kind)
         tcw_pkg::CMD_WRITE: col_next = col_x + 1'b1;
         tcw_pkg::CMD_BACK:  col_next = (col_ff != '0) ? col_x - 1'b1 : col_x;
         tcw_pkg::CMD_TAB:   col_next = col_x - (col_x % TAB_X) + TAB_X;
         tcw_pkg::CMD_CR,
         tcw_pkg::CMD_LF:    col_next = '0;
         default:            col_next = col_x;
      endcase
   end

   assign wrap = (col_next >= COLS_X);
   assign step = wrap || (head_cmd.kind == tcw_pkg::CMD_LF);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      top_in        = top_ff;
      fill_addr_in  = fill_addr_ff;
      fill_last_in  = fill_last_ff;
      reply_read_in = reply_read_ff;
      mem_we        = 1'b0;
      mem_wa        = fill_addr_ff;
      mem_wd        = blank;
      mem_re        = 1'b0;
      mem_ra        = read_addr;
      pop           = 1'b0;
      load          = 1'b0;
      load_read     = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            mem_wd = '0;
            if (fill_addr_ff == fill_last_ff) begin
               state_in = ST_IDLE;
            end else begin
               fill_addr_in = fill_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (!empty && out_free) begin
               pop = 1'b1;
               case (head_cmd.kind)
                  tcw_pkg::CMD_WRITE, tcw_pkg::CMD_BACK, tcw_pkg::CMD_TAB,
                  tcw_pkg::CMD_CR, tcw_pkg::CMD_LF: begin
                     if (head_cmd.kind == tcw_pkg::CMD_WRITE) begin
                        mem_we = 1'b1;
                        mem_wa = cursor_addr;
                        mem_wd = {attr, head_cmd.char_byte};
                     end
                     col_in = wrap ? '0 : col_next[tcw_pkg::COL_W-1:0];
                     if (step && row_ff == LAST_ROW) begin
                        // scroll: old top row becomes the new blank bottom row
                        top_in        = (top_ff == LAST_ROW) ? '0 : top_ff + 1'b1;
                        fill_addr_in  = top_base;
                        fill_last_in  = top_base + COLS_A - 1'b1;
                        reply_read_in = 1'b0;
                        state_in      = ST_FILL;
                     end else begin
                        if (step) begin
                           row_in = row_ff + 1'b1;
                        end
                        load = 1'b1;
                     end
                  end
                  tcw_pkg::CMD_CLEAR: begin
                     col_in        = '0;
                     row_in        = '0;
                     top_in        = '0;
                     fill_addr_in  = '0;
                     fill_last_in  = LAST_CELL;
                     reply_read_in = 1'b0;
                     state_in      = ST_FILL;
                  end
                  tcw_pkg::CMD_READ: begin
                     mem_re   = 1'b1;
                     state_in = ST_READ;
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               load      = 1'b1;
               load_read = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               reply_read_in = 1'b1;
               state_in      = ST_REPLY;
            end
         end
         ST_FILL: begin
            mem_we = 1'b1;
            if (fill_addr_ff == fill_last_ff) begin
               state_in = ST_REPLY;
            end else begin
               fill_addr_in = fill_addr_ff + 1'b1;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               load      = 1'b1;
               load_read = reply_read_ff;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff.cursor_location <= tcw_pkg::LOC_W'(row_in) *
                                   tcw_pkg::LOC_W'(tcw_pkg::COLUMNS) +
                                   tcw_pkg::LOC_W'(col_in);
         rsp_ff.top_row         <= top_in;
         rsp_ff.read_cell       <= load_read ? rd_data_ff : '0;
         rsp_ff.read_valid      <= load_read;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         col_ff        <= '0;
         row_ff        <= '0;
         top_ff        <= '0;
         fill_addr_ff  <= '0;
         fill_last_ff  <= LAST_CELL;
         reply_read_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         top_ff        <= top_in;
         fill_addr_ff  <= fill_addr_in;
         fill_last_ff  <= fill_last_in;
         reply_read_ff <= reply_read_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // cell store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= store[mem_ra];
      end
   end

endmodule

// File: hdl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// port-level checks of the text console writer
// ----------------------------------------------------------------------------
module tcw_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input tcw_pkg::rsp_type           rsp_payload
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // reset starts the clearing pass and empties the output
   assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("block not held after reset");

   // non-read responses carry no cell
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.read_valid |-> rsp_payload.read_cell == '0)
      else $error("cell data without a read");

   // cursor and top row stay on the screen
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.top_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS) &&
                    rsp_payload.cursor_location < tcw_pkg::LOC_W'(tcw_pkg::CELL_COUNT))
      else $error("cursor or top row off screen");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
